// ===== hw/rtl/qai_pkg.sv =====
// Shared widths, types and constants for the quaternion angular integrator.
// Used by qai_isqrt, qai_div and the quaternion_angular_integrate top level.
// No dependencies.
package qai_pkg;

    // Field and lane counts
    localparam int FW          = 16;   // every stream field is 16 bits
    localparam int NLANE       = 4;    // quaternion lanes: x, y, z, w
    localparam int NAXIS       = 3;    // angular velocity axes: x, y, z
    localparam int Q15_FRAC    = 15;   // fraction bits of a Q1.15 value

    // Integration arithmetic
    localparam int DW          = 33;   // omega * dt, signed
    localparam int PW          = 49;   // (omega * dt) * q, signed
    localparam int SW          = 50;   // q * 2^25 + product sum, signed
    localparam int SCALE_SH    = 25;   // aligns q with the product scale
    localparam int MW          = 49;   // magnitude of the sum

    // Leading-one search over the magnitudes, in byte groups
    localparam int GIW         = 3;
    localparam int GRP_W       = 1 << GIW;
    localparam int NGRP        = (MW + GRP_W - 1) / GRP_W;
    localparam int PADW        = NGRP * GRP_W;
    localparam int POSW        = 2 * GIW;

    // Normalized magnitudes: the largest one has its top bit at TPOS
    localparam int TW          = 30;
    localparam int TPOS        = TW - 1;
    localparam int WIDEW       = MW + TPOS;
    localparam int CSW         = TW + GRP_W - 1;
    localparam int SQW         = 2 * TW;
    localparam int NW          = SQW + 2;

    // Square root and division
    localparam int RW          = NW / 2;          // root bits, one per stage
    localparam int RMW         = RW + 4;          // partial remainder
    localparam int QW          = FW;              // quotient bits
    localparam int DIV_STEPS   = QW;              // one quotient bit per stage
    localparam int DRW         = RW;              // division remainder
    localparam int NUW         = TW + Q15_FRAC + 1;

    // Front stages ahead of the square root: input, products, sums,
    // magnitudes, group search, position, two shifts, squares, norm
    localparam int PRE_STAGES  = 10;

    // Configuration port
    localparam int PAW         = 3;
    localparam int REG_IDX_W   = 1;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
    localparam logic [FW-1:0] TIME_STEP_RESET = 16'd1092;

    // Result coding
    localparam logic [FW-1:0] Q15_MAX = 16'h7FFF;
    localparam logic [FW-1:0] Q15_ONE = 16'h8000;

    // Pipeline control between the top level and its arithmetic units
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    // What rides along with the norm through the square root
    typedef struct packed {
        logic                         zero;
        logic [NLANE-1:0]             neg;
        logic [NLANE-1:0][TW-1:0]     t;
    } norm_side_t;

endpackage

// ===== hw/rtl/quaternion_angular_integrate.sv =====
// Quaternion first-order integration with renormalization, fully pipelined.
// Depends on qai_pkg, qai_isqrt and qai_div.
//
// Usage:
//   The slave stream takes one word per orientation: a Q1.15 quaternion and
//   a Q7.8 angular velocity. The master stream returns the advanced quaternion,
//   renormalized to unit length and saturated to Q1.15. A zero norm returns the
//   identity quaternion. The APB port holds time_step (Q0.16 seconds) at
//   address 0; write it only while no word is in flight.
//   Pipeline: an accepted input word passes through ten front stages
//   (products, sums, normalizing shift, squares), 31 square-root stages at
//   one root bit each, and 17 divider stages: a rounding preparation stage,
//   then one quotient bit per stage, before the output queue.
//   Throughput: one word per cycle while the receiver keeps up.
//   A two-entry output queue decouples the sides: s_tready depends only on
//   its fill, so when the receiver stalls the queue fills and the whole
//   pipeline holds in place; nothing is lost or repeated.
//   Reset empties the pipeline and the queue and sets time_step to 1092.
module quaternion_angular_integrate
    import qai_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    // orient_x, orient_y, orient_z, orient_w, omega_x, omega_y, omega_z
    input  logic [7*FW-1:0]    s_tdata,
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // new_x, new_y, new_z, new_w
    output logic [NLANE*FW-1:0] m_tdata,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PAW-1:0]     paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [FW-1:0] time_step_reg;
    logic          cfg_wr;
    logic          cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PAW-1 -: REG_IDX_W] == REG_TIME_STEP);
    assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
    assign prdata  = cfg_hit ? {16'b0, time_step_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
        end else if (cfg_wr) begin
            time_step_reg <= pwdata[FW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything advances while the output queue has room
    // ------------------------------------------------------------------
    logic       en;
    logic [1:0] fifo_cnt_reg;
    logic [PRE_STAGES-1:0] pre_v_reg;

    assign en       = (fifo_cnt_reg != 2'd2);
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_v_reg <= '0;
        end else if (en) begin
            pre_v_reg <= {pre_v_reg[PRE_STAGES-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: unpack the word and scale the angular velocity by dt
    // ------------------------------------------------------------------
    logic signed [FW-1:0] orient_x, orient_y, orient_z, orient_w;
    logic signed [FW-1:0] omega_x, omega_y, omega_z;
    logic signed [FW:0]   dt_s;
    logic signed [FW-1:0] q_a_next [NLANE];
    logic signed [DW-1:0] d_a_next [NAXIS];
    logic signed [FW-1:0] q_a_reg  [NLANE];
    logic signed [DW-1:0] d_a_reg  [NAXIS];

    assign orient_x = s_tdata[0*FW +: FW];
    assign orient_y = s_tdata[1*FW +: FW];
    assign orient_z = s_tdata[2*FW +: FW];
    assign orient_w = s_tdata[3*FW +: FW];
    assign omega_x  = s_tdata[4*FW +: FW];
    assign omega_y  = s_tdata[5*FW +: FW];
    assign omega_z  = s_tdata[6*FW +: FW];
    assign dt_s     = $signed({1'b0, time_step_reg});

    always_comb begin
        q_a_next[0] = orient_x;
        q_a_next[1] = orient_y;
        q_a_next[2] = orient_z;
        q_a_next[3] = orient_w;
        d_a_next[0] = DW'(omega_x) * DW'(dt_s);
        d_a_next[1] = DW'(omega_y) * DW'(dt_s);
        d_a_next[2] = DW'(omega_z) * DW'(dt_s);
    end

    // ------------------------------------------------------------------
    // Stage B: the twelve products of the Hamilton product (d.w is zero)
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p_b_next [NLANE][NAXIS];
    logic signed [PW-1:0] p_b_reg  [NLANE][NAXIS];
    logic signed [FW-1:0] q_b_reg  [NLANE];

    always_comb begin
        // x lane: dx*qw + dy*qz - dz*qy
        p_b_next[0][0] = PW'(d_a_reg[0]) * PW'(q_a_reg[3]);
        p_b_next[0][1] = PW'(d_a_reg[1]) * PW'(q_a_reg[2]);
        p_b_next[0][2] = PW'(d_a_reg[2]) * PW'(q_a_reg[1]);
        // y lane: dy*qw + dz*qx - dx*qz
        p_b_next[1][0] = PW'(d_a_reg[1]) * PW'(q_a_reg[3]);
        p_b_next[1][1] = PW'(d_a_reg[2]) * PW'(q_a_reg[0]);
        p_b_next[1][2] = PW'(d_a_reg[0]) * PW'(q_a_reg[2]);
        // z lane: dz*qw + dx*qy - dy*qx
        p_b_next[2][0] = PW'(d_a_reg[2]) * PW'(q_a_reg[3]);
        p_b_next[2][1] = PW'(d_a_reg[0]) * PW'(q_a_reg[1]);
        p_b_next[2][2] = PW'(d_a_reg[1]) * PW'(q_a_reg[0]);
        // w lane: -(dx*qx + dy*qy + dz*qz)
        p_b_next[3][0] = PW'(d_a_reg[0]) * PW'(q_a_reg[0]);
        p_b_next[3][1] = PW'(d_a_reg[1]) * PW'(q_a_reg[1]);
        p_b_next[3][2] = PW'(d_a_reg[2]) * PW'(q_a_reg[2]);
    end

    // ------------------------------------------------------------------
    // Stage C: s = q + p/2, kept exact in units of 2^-40
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s_c_next [NLANE];
    logic signed [SW-1:0] s_c_reg  [NLANE];

    always_comb begin
        logic signed [SW-1:0] a0, a1, a2, qe, pair;
        for (int l = 0; l < NLANE; l++) begin
            a0   = SW'(p_b_reg[l][0]);
            a1   = SW'(p_b_reg[l][1]);
            a2   = SW'(p_b_reg[l][2]);
            qe   = SW'(q_b_reg[l]);
            pair = a0 + a1;
            if (l == NLANE - 1) begin
                s_c_next[l] = (qe <<< SCALE_SH) - pair - a2;
            end else begin
                s_c_next[l] = (qe <<< SCALE_SH) + pair - a2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: sign and magnitude; the OR of all magnitudes has the same
    // leading one as the largest magnitude
    // ------------------------------------------------------------------
    logic [MW-1:0]    mag_d_next [NLANE];
    logic [NLANE-1:0] neg_d_next;
    logic [MW-1:0]    or_d_next;
    logic [MW-1:0]    mag_d_reg  [NLANE];
    logic [NLANE-1:0] neg_d_reg;
    logic [MW-1:0]    or_d_reg;

    always_comb begin
        logic signed [SW-1:0] absv;
        or_d_next = '0;
        for (int l = 0; l < NLANE; l++) begin
            neg_d_next[l] = s_c_reg[l][SW-1];
            absv          = neg_d_next[l] ? -s_c_reg[l] : s_c_reg[l];
            mag_d_next[l] = absv[MW-1:0];
            or_d_next     = or_d_next | mag_d_next[l];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: leading one inside each byte group
    // ------------------------------------------------------------------
    logic [NGRP-1:0] grp_any_e_next;
    logic [GIW-1:0]  grp_idx_e_next [NGRP];
    logic [NGRP-1:0] grp_any_e_reg;
    logic [GIW-1:0]  grp_idx_e_reg  [NGRP];
    logic [MW-1:0]    mag_e_reg [NLANE];
    logic [NLANE-1:0] neg_e_reg;

    always_comb begin
        logic [PADW-1:0] padded;
        padded = PADW'(or_d_reg);
        for (int g = 0; g < NGRP; g++) begin
            grp_any_e_next[g] = |padded[g*GRP_W +: GRP_W];
            grp_idx_e_next[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                if (padded[g*GRP_W + b]) begin
                    grp_idx_e_next[g] = GIW'(b);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage F: position of the leading one, zero-norm flag
    // ------------------------------------------------------------------
    logic [POSW-1:0]  pos_f_next;
    logic             zero_f_next;
    logic [POSW-1:0]  pos_f_reg;
    logic             zero_f_reg;
    logic [MW-1:0]    mag_f_reg [NLANE];
    logic [NLANE-1:0] neg_f_reg;

    always_comb begin
        pos_f_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (grp_any_e_reg[g]) begin
                pos_f_next = {GIW'(g), grp_idx_e_reg[g]};
            end
        end
        zero_f_next = ~|grp_any_e_reg;
    end

    // ------------------------------------------------------------------
    // Stages G and H: (mag << 29) >> pos puts the largest magnitude in
    // [2^29, 2^30); whole bytes first, then the remaining bits
    // ------------------------------------------------------------------
    logic [CSW-1:0]   coarse_g_next [NLANE];
    logic [CSW-1:0]   coarse_g_reg  [NLANE];
    logic [GIW-1:0]   fine_g_reg;
    logic             zero_g_reg;
    logic [NLANE-1:0] neg_g_reg;

    always_comb begin
        logic [WIDEW-1:0] wide;
        logic [WIDEW-1:0] shifted;
        for (int l = 0; l < NLANE; l++) begin
            wide    = {mag_f_reg[l], {TPOS{1'b0}}};
            shifted = wide >> {pos_f_reg[POSW-1:GIW], {GIW{1'b0}}};
            coarse_g_next[l] = shifted[CSW-1:0];
        end
    end

    logic [TW-1:0]    t_h_next [NLANE];
    logic [TW-1:0]    t_h_reg  [NLANE];
    logic             zero_h_reg;
    logic [NLANE-1:0] neg_h_reg;

    always_comb begin
        logic [CSW-1:0] fine;
        for (int l = 0; l < NLANE; l++) begin
            fine        = coarse_g_reg[l] >> fine_g_reg;
            t_h_next[l] = fine[TW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage I: squares. Stage J: squared norm.
    // ------------------------------------------------------------------
    logic [SQW-1:0]   sq_i_next [NLANE];
    logic [SQW-1:0]   sq_i_reg  [NLANE];
    logic [TW-1:0]    t_i_reg   [NLANE];
    logic             zero_i_reg;
    logic [NLANE-1:0] neg_i_reg;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            sq_i_next[l] = SQW'(t_h_reg[l]) * SQW'(t_h_reg[l]);
        end
    end

    logic [NW-1:0] n_j_next;
    logic [NW-1:0] n_j_reg;
    norm_side_t    side_j_next;
    norm_side_t    side_j_reg;

    always_comb begin
        n_j_next = (NW'(sq_i_reg[0]) + NW'(sq_i_reg[1]))
                 + (NW'(sq_i_reg[2]) + NW'(sq_i_reg[3]));
        side_j_next.zero = zero_i_reg;
        side_j_next.neg  = neg_i_reg;
        for (int l = 0; l < NLANE; l++) begin
            side_j_next.t[l] = t_i_reg[l];
        end
    end

    // Front stage payloads.
    always_ff @(posedge aclk) begin
        if (en) begin
            q_a_reg <= q_a_next;
            d_a_reg <= d_a_next;

            p_b_reg <= p_b_next;
            q_b_reg <= q_a_reg;

            s_c_reg <= s_c_next;

            mag_d_reg <= mag_d_next;
            neg_d_reg <= neg_d_next;
            or_d_reg  <= or_d_next;

            grp_any_e_reg <= grp_any_e_next;
            grp_idx_e_reg <= grp_idx_e_next;
            mag_e_reg     <= mag_d_reg;
            neg_e_reg     <= neg_d_reg;

            pos_f_reg  <= pos_f_next;
            zero_f_reg <= zero_f_next;
            mag_f_reg  <= mag_e_reg;
            neg_f_reg  <= neg_e_reg;

            coarse_g_reg <= coarse_g_next;
            fine_g_reg   <= pos_f_reg[GIW-1:0];
            zero_g_reg   <= zero_f_reg;
            neg_g_reg    <= neg_f_reg;

            t_h_reg    <= t_h_next;
            zero_h_reg <= zero_g_reg;
            neg_h_reg  <= neg_g_reg;

            sq_i_reg   <= sq_i_next;
            t_i_reg    <= t_h_reg;
            zero_i_reg <= zero_h_reg;
            neg_i_reg  <= neg_h_reg;

            n_j_reg    <= n_j_next;
            side_j_reg <= side_j_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root of the norm, then the per-lane rounded division
    // ------------------------------------------------------------------
    pipe_ctl_t  isq_ctl;
    logic       isq_valid;
    logic [RW-1:0] isq_root;
    norm_side_t isq_side;

    assign isq_ctl.en    = en;
    assign isq_ctl.valid = pre_v_reg[PRE_STAGES-1];

    qai_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (isq_ctl),
        .n         (n_j_reg),
        .side_in   (side_j_reg),
        .valid_out (isq_valid),
        .root      (isq_root),
        .side_out  (isq_side)
    );

    pipe_ctl_t div_ctl;
    logic      div_valid;
    logic [NLANE-1:0][QW-1:0] div_quot;
    logic      div_zero;
    logic [NLANE-1:0] div_neg;

    assign div_ctl.en    = en;
    assign div_ctl.valid = isq_valid;

    qai_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .root      (isq_root),
        .side_in   (isq_side),
        .valid_out (div_valid),
        .quot      (div_quot),
        .zero_out  (div_zero),
        .neg_out   (div_neg)
    );

    // ------------------------------------------------------------------
    // Sign, saturation and the zero-norm identity
    // ------------------------------------------------------------------
    function automatic logic [FW-1:0] encode_q15(input logic neg, input logic [QW-1:0] o);
        logic [FW-1:0] val;
        if (neg && (o != '0)) begin
            val = ~o + FW'(1);
        end else if (o[QW-1]) begin
            val = Q15_MAX;
        end else begin
            val = o;
        end
        return val;
    endfunction

    logic signed [FW-1:0] new_x, new_y, new_z, new_w;
    logic [NLANE*FW-1:0]  enc_word;

    always_comb begin
        if (div_zero) begin
            new_x = '0;
            new_y = '0;
            new_z = '0;
            new_w = Q15_MAX;
        end else begin
            new_x = encode_q15(div_neg[0], div_quot[0]);
            new_y = encode_q15(div_neg[1], div_quot[1]);
            new_z = encode_q15(div_neg[2], div_quot[2]);
            new_w = encode_q15(div_neg[3], div_quot[3]);
        end
        enc_word = {new_w, new_z, new_y, new_x};
    end

    // ------------------------------------------------------------------
    // Two-entry output queue
    // ------------------------------------------------------------------
    logic [NLANE*FW-1:0] fifo_reg [2];
    logic fifo_wr_ptr_reg;
    logic fifo_rd_ptr_reg;
    logic fifo_wr;
    logic fifo_rd;

    assign fifo_wr  = en & div_valid;
    assign fifo_rd  = m_tvalid & m_tready;
    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tdata  = fifo_reg[fifo_rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_cnt_reg    <= 2'd0;
            fifo_wr_ptr_reg <= 1'b0;
            fifo_rd_ptr_reg <= 1'b0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_reg + 2'(fifo_wr) - 2'(fifo_rd);
            if (fifo_wr) begin
                fifo_wr_ptr_reg <= ~fifo_wr_ptr_reg;
            end
            if (fifo_rd) begin
                fifo_rd_ptr_reg <= ~fifo_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_reg[fifo_wr_ptr_reg] <= enc_word;
        end
    end

`ifndef ASSERT_OFF
    // The queue never holds more than its two entries.
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg != 2'd3)
        else $error("output queue count out of range");

    // After the normalizing shift the largest magnitude has its top bit set.
    a_norm_msb: assert property (@(posedge aclk) disable iff (!aresetn)
        (pre_v_reg[7] && !zero_h_reg) |->
        (t_h_reg[0][TPOS] || t_h_reg[1][TPOS] || t_h_reg[2][TPOS] || t_h_reg[3][TPOS]))
        else $error("normalized magnitudes lack a leading one");

    // A nonzero norm gives a root of at least 2^29.
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (isq_valid && !isq_side.zero) |-> (isq_root[RW-1:TPOS] != '0))
        else $error("square root below normalized range");

    // No quotient goes beyond one in Q1.15.
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_zero) |->
        ((div_quot[0] <= Q15_ONE) && (div_quot[1] <= Q15_ONE) &&
         (div_quot[2] <= Q15_ONE) && (div_quot[3] <= Q15_ONE)))
        else $error("quotient exceeds unit magnitude");
`endif

endmodule

// ===== hw/rtl/qai_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries the normalized magnitudes and signs alongside; uses qai_pkg.
module qai_isqrt
    import qai_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  pipe_ctl_t         ctl,
    input  logic [NW-1:0]     n,
    input  norm_side_t        side_in,
    output logic              valid_out,
    output logic [RW-1:0]     root,
    output norm_side_t        side_out
);

    logic [RW-1:0]  v_reg;
    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [NW-1:0]  rest_reg [RW];
    norm_side_t     side_reg [RW];

    logic [RMW-1:0] rem_src  [RW];
    logic [RW-1:0]  root_src [RW];
    logic [NW-1:0]  rest_src [RW];
    norm_side_t     side_src [RW];

    logic [RMW-1:0] rem_next  [RW];
    logic [RW-1:0]  root_next [RW];
    logic [NW-1:0]  rest_next [RW];

    // Each stage takes the word of the stage before it.
    always_comb begin
        rem_src[0]  = '0;
        root_src[0] = '0;
        rest_src[0] = n;
        side_src[0] = side_in;
        for (int k = 1; k < RW; k++) begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            rest_src[k] = rest_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    // One restoring step per stage: bring down two bits, try root*4+1.
    always_comb begin
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        for (int k = 0; k < RW; k++) begin
            rem2  = {rem_src[k][RMW-3:0], rest_src[k][NW-1 -: 2]};
            trial = RMW'({root_src[k], 2'b01});
            if (rem2 >= trial) begin
                rem_next[k]  = rem2 - trial;
                root_next[k] = {root_src[k][RW-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem2;
                root_next[k] = {root_src[k][RW-2:0], 1'b0};
            end
            rest_next[k] = rest_src[k] << 2;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ctl.en) begin
            v_reg <= {v_reg[RW-2:0], ctl.valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int k = 0; k < RW; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rest_reg[k] <= rest_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign valid_out = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

// ===== hw/rtl/qai_div.sv =====
// Pipelined four-lane divider: round(t * 2^15 / root), one quotient bit a stage.
// Depends on qai_pkg for widths and the side-band struct.
module qai_div
    import qai_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pipe_ctl_t                   ctl,
    input  logic [RW-1:0]               root,
    input  norm_side_t                  side_in,
    output logic                        valid_out,
    output logic [NLANE-1:0][QW-1:0]    quot,
    output logic                        zero_out,
    output logic [NLANE-1:0]            neg_out
);

    // Preparation stage: numerator with half the divisor added for rounding
    logic              prep_v_reg;
    logic [DRW-1:0]    prep_rem_reg [NLANE];
    logic [QW-1:0]     prep_low_reg [NLANE];
    logic [RW-1:0]     prep_r_reg;
    logic              prep_zero_reg;
    logic [NLANE-1:0]  prep_neg_reg;
    logic [DRW-1:0]    prep_rem_next [NLANE];
    logic [QW-1:0]     prep_low_next [NLANE];

    // Quotient stages
    logic [DIV_STEPS-1:0] v_reg;
    logic [DRW-1:0]    rem_reg  [DIV_STEPS][NLANE];
    logic [QW-1:0]     low_reg  [DIV_STEPS][NLANE];
    logic [QW-1:0]     quot_reg [DIV_STEPS][NLANE];
    logic [RW-1:0]     r_reg    [DIV_STEPS];
    logic              zero_reg [DIV_STEPS];
    logic [NLANE-1:0]  neg_reg  [DIV_STEPS];

    logic [DRW-1:0]    rem_src  [DIV_STEPS][NLANE];
    logic [QW-1:0]     low_src  [DIV_STEPS][NLANE];
    logic [QW-1:0]     quot_src [DIV_STEPS][NLANE];
    logic [RW-1:0]     r_src    [DIV_STEPS];
    logic              zero_src [DIV_STEPS];
    logic [NLANE-1:0]  neg_src  [DIV_STEPS];

    logic [DRW-1:0]    rem_next  [DIV_STEPS][NLANE];
    logic [QW-1:0]     low_next  [DIV_STEPS][NLANE];
    logic [QW-1:0]     quot_next [DIV_STEPS][NLANE];

    // The top numerator bits already lie below the divisor, since the
    // quotient never exceeds 2^15.
    always_comb begin
        logic [NUW-1:0] nu;
        for (int l = 0; l < NLANE; l++) begin
            nu = NUW'({side_in.t[l], {Q15_FRAC{1'b0}}}) + NUW'(root >> 1);
            prep_rem_next[l] = DRW'(nu[NUW-1:QW]);
            prep_low_next[l] = nu[QW-1:0];
        end
    end

    // Stage inputs.
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            rem_src[0][l]  = prep_rem_reg[l];
            low_src[0][l]  = prep_low_reg[l];
            quot_src[0][l] = '0;
        end
        r_src[0]    = prep_r_reg;
        zero_src[0] = prep_zero_reg;
        neg_src[0]  = prep_neg_reg;
        for (int k = 1; k < DIV_STEPS; k++) begin
            for (int l = 0; l < NLANE; l++) begin
                rem_src[k][l]  = rem_reg[k-1][l];
                low_src[k][l]  = low_reg[k-1][l];
                quot_src[k][l] = quot_reg[k-1][l];
            end
            r_src[k]    = r_reg[k-1];
            zero_src[k] = zero_reg[k-1];
            neg_src[k]  = neg_reg[k-1];
        end
    end

    // Restoring division step: shift in one numerator bit, subtract if it fits.
    always_comb begin
        logic [DRW:0] rem2;
        logic [DRW:0] dvs;
        for (int k = 0; k < DIV_STEPS; k++) begin
            dvs = {1'b0, r_src[k]};
            for (int l = 0; l < NLANE; l++) begin
                rem2 = {rem_src[k][l], low_src[k][l][QW-1]};
                low_next[k][l] = low_src[k][l] << 1;
                if (rem2 >= dvs) begin
                    rem_next[k][l]  = DRW'(rem2 - dvs);
                    quot_next[k][l] = {quot_src[k][l][QW-2:0], 1'b1};
                end else begin
                    rem_next[k][l]  = DRW'(rem2);
                    quot_next[k][l] = {quot_src[k][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_v_reg <= 1'b0;
            v_reg      <= '0;
        end else if (ctl.en) begin
            prep_v_reg <= ctl.valid;
            v_reg      <= {v_reg[DIV_STEPS-2:0], prep_v_reg};
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int l = 0; l < NLANE; l++) begin
                prep_rem_reg[l] <= prep_rem_next[l];
                prep_low_reg[l] <= prep_low_next[l];
            end
            prep_r_reg    <= root;
            prep_zero_reg <= side_in.zero;
            prep_neg_reg  <= side_in.neg;
            for (int k = 0; k < DIV_STEPS; k++) begin
                for (int l = 0; l < NLANE; l++) begin
                    rem_reg[k][l]  <= rem_next[k][l];
                    low_reg[k][l]  <= low_next[k][l];
                    quot_reg[k][l] <= quot_next[k][l];
                end
                r_reg[k]    <= r_src[k];
                zero_reg[k] <= zero_src[k];
                neg_reg[k]  <= neg_src[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            quot[l] = quot_reg[DIV_STEPS-1][l];
        end
    end

    assign valid_out = v_reg[DIV_STEPS-1];
    assign zero_out  = zero_reg[DIV_STEPS-1];
    assign neg_out   = neg_reg[DIV_STEPS-1];

endmodule
